### hdl/softmax_reciprocal_divider_defines.svh
// assertion helpers for the softmax reciprocal divider checker
`ifndef SOFTMAX_RECIPROCAL_DIVIDER_DEFINES_SVH
`define SOFTMAX_RECIPROCAL_DIVIDER_DEFINES_SVH

// concurrent check on clk_i, off while rst_ni is low
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequent must hold in the same cycle
`define SRD_ASSERT_SAME(lbl, ante, cons, msg) `SRD_ASSERT(lbl, (ante) |-> (cons), msg)

// consequent must hold in the next cycle
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) `SRD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/srd_pkg.sv
package srd_pkg;

  // fixed field widths, scale factor and default fraction bits
  localparam int unsigned VALUE_WIDTH       = 8;
  localparam int unsigned DIVISOR_WIDTH     = 24;
  localparam int unsigned QUOTIENT_WIDTH    = 8;
  localparam int unsigned SCALE_FACTOR      = 255;
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]   value;
    logic [DIVISOR_WIDTH-1:0] divisor;
    logic [DIVISOR_WIDTH-1:0] rounding;
  } srd_in_req_t;

  typedef struct packed {
    logic [QUOTIENT_WIDTH-1:0] quotient;
    logic                      divide_by_zero;
  } srd_out_req_t;

endpackage

### hdl/softmax_reciprocal_divider.sv
// Softmax reciprocal divider. Each request carries an 8-bit value, a 24-bit divisor and a
// 24-bit rounding term; the block forms dividend = value*255 + rounding and returns the low
// eight bits of either dividend/divisor (exact_mode = 1) or of
// (dividend * floor(2^(FRACTION_BITS+L) / divisor)) >> (FRACTION_BITS+L), where L is the
// index of the divisor's top set bit (exact_mode = 0, the reset value). A zero divisor gives
// quotient 0 with divide_by_zero set. exact_mode is written through cfg_we_i/cfg_wdata_i and
// is sampled per request when it enters. Throughput is one request per clock while in_stall_o
// is low. Every request passes through the restoring divide chain, which retires one
// quotient bit per pipeline stage and is shared by both modes (in reciprocal mode it divides
// a power of two by the normalized divisor). A two-entry output (result register plus skid
// register) keeps the pipe moving in the cycle in which out_stall_i rises; in_stall_o is a
// registered signal that is high only while the skid register is occupied.
module softmax_reciprocal_divider #(
  parameter int unsigned FRACTION_BITS = srd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  input  srd_pkg::srd_in_req_t in_req_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  output srd_pkg::srd_out_req_t out_req_o,
  input  logic                 out_stall_i
);

  import srd_pkg::*;

  // widths derived from the field sizes and the fraction precision
  localparam int unsigned W        = DIVISOR_WIDTH;
  localparam int unsigned DvdW     = DIVISOR_WIDTH + 1;  // value*255 + rounding
  localparam int unsigned RecipW   = FRACTION_BITS + 1;  // reciprocal is at most 2^F
  localparam int unsigned NumSteps = (DvdW > RecipW) ? DvdW : RecipW;
  localparam int unsigned PrdW     = DvdW + RecipW;
  localparam int unsigned TopW     = $clog2(DIVISOR_WIDTH);
  localparam int unsigned ShW      = $clog2(FRACTION_BITS + DIVISOR_WIDTH);
  // reciprocal mode divides 2^(F+W-1) by the normalized divisor: the bits above the
  // last NumSteps are preloaded as the starting remainder
  localparam int unsigned InitExp  = FRACTION_BITS + DIVISOR_WIDTH - 1 - NumSteps;
  localparam logic [W-1:0] RecipRem = {{(W-1){1'b0}}, 1'b1} << InitExp;
  localparam logic [TopW-1:0] TopMax = TopW'(W - 1);

  // front end: scaled dividend, raw divisor, top bit index
  typedef struct packed {
    logic            mode;
    logic            dz;
    logic [DvdW-1:0] dvd;
    logic [W-1:0]    den;
    logic [TopW-1:0] top;
  } front_t;

  // one slot of the divide chain: remainder and numerator/quotient shift register
  typedef struct packed {
    logic                mode;
    logic                dz;
    logic [DvdW-1:0]     dvd;
    logic [TopW-1:0]     top;
    logic [W-1:0]        den;
    logic [W-1:0]        rem;
    logic [NumSteps-1:0] num;
  } step_t;

  // after the multiply
  typedef struct packed {
    logic                      mode;
    logic                      dz;
    logic [TopW-1:0]           top;
    logic [QUOTIENT_WIDTH-1:0] quo;
    logic [PrdW-1:0]           prod;
  } mul_t;

  logic exact_mode_q;

  logic en;

  logic   p0_vld_q, p1_vld_q;
  front_t p0_q, p1_q;
  front_t p0_d, p1_d;

  logic [NumSteps:0] dv_vld_q;
  step_t             dv_q [NumSteps+1];
  step_t             dv0_d;

  logic mp_vld_q;
  mul_t mp_q, mp_d;

  logic         out_vld_q, skid_full_q, skid_full_d;
  srd_out_req_t out_q, out_d, skid_q;

  logic [TopW-1:0]     norm_sh;
  logic [ShW-1:0]      res_sh;
  logic [PrdW-1:0]     res_shifted;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      exact_mode_q <= cfg_wdata_i;
    end
  end

  // whole pipe advances unless the skid register is holding a result
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // stage 0: capture request and scale the value
  always_comb begin
    p0_d      = '0;
    p0_d.mode = exact_mode_q;
    p0_d.dz   = (in_req_i.divisor == '0);
    p0_d.dvd  = DvdW'(in_req_i.value) * DvdW'(SCALE_FACTOR) + DvdW'(in_req_i.rounding);
    p0_d.den  = in_req_i.divisor;
  end

  // stage 1: leading-one position of the divisor
  always_comb begin
    p1_d     = p0_q;
    p1_d.top = '0;
    for (int i = 0; i < W; i++) begin
      if (p0_q.den[i]) begin
        p1_d.top = TopW'(i);
      end
    end
  end

  // stage 2: normalize the divisor and set up the divide
  assign norm_sh = TopMax - p1_q.top;

  always_comb begin
    dv0_d.mode = p1_q.mode;
    dv0_d.dz   = p1_q.dz;
    dv0_d.dvd  = p1_q.dvd;
    dv0_d.top  = p1_q.top;
    if (p1_q.mode) begin
      dv0_d.den = p1_q.den;
      dv0_d.rem = '0;
      dv0_d.num = NumSteps'(p1_q.dvd);
    end else begin
      dv0_d.den = p1_q.den << norm_sh;
      dv0_d.rem = RecipRem;
      dv0_d.num = '0;
    end
  end

  // control: valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      mp_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q  <= in_valid_i;
      p1_vld_q  <= p0_vld_q;
      dv_vld_q  <= {dv_vld_q[NumSteps-1:0], p1_vld_q};
      mp_vld_q  <= dv_vld_q[NumSteps];
      out_vld_q <= mp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      dv_q[0]  <= dv0_d;
      mp_q     <= mp_d;
      out_q    <= out_d;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    step_t      nxt;

    assign trial = {dv_q[k].rem, dv_q[k].num[NumSteps-1]};
    assign diff  = trial - {1'b0, dv_q[k].den};
    assign ge    = (trial >= {1'b0, dv_q[k].den});

    always_comb begin
      nxt     = dv_q[k];
      nxt.rem = ge ? diff[W-1:0] : trial[W-1:0];
      nxt.num = {dv_q[k].num[NumSteps-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  // multiply by the reciprocal
  always_comb begin
    mp_d.mode = dv_q[NumSteps].mode;
    mp_d.dz   = dv_q[NumSteps].dz;
    mp_d.top  = dv_q[NumSteps].top;
    mp_d.quo  = dv_q[NumSteps].num[QUOTIENT_WIDTH-1:0];
    mp_d.prod = PrdW'(dv_q[NumSteps].dvd) * PrdW'(dv_q[NumSteps].num[RecipW-1:0]);
  end

  // final shift and select
  assign res_sh      = ShW'(FRACTION_BITS) + ShW'(mp_q.top);
  assign res_shifted = mp_q.prod >> res_sh;

  always_comb begin
    out_d.divide_by_zero = mp_q.dz;
    if (mp_q.dz) begin
      out_d.quotient = '0;
    end else if (mp_q.mode) begin
      out_d.quotient = mp_q.quo;
    end else begin
      out_d.quotient = res_shifted[QUOTIENT_WIDTH-1:0];
    end
  end

  // skid register catches the result that was in flight when the sink stalled
  always_comb begin
    skid_full_d = skid_full_q;
    if (skid_full_q) begin
      if (!out_stall_i) begin
        skid_full_d = 1'b0;
      end
    end else if (out_vld_q && out_stall_i) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_q <= out_q;
    end
  end

  assign out_valid_o = skid_full_q | out_vld_q;
  assign out_req_o   = skid_full_q ? skid_q : out_q;

endmodule

### hdl/srd_checker.sv
`include "softmax_reciprocal_divider_defines.svh"

module srd_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input srd_pkg::srd_out_req_t out_req_o,
  input logic                  out_stall_i
);

  import srd_pkg::*;

  // a stalled result stays put
  `SRD_ASSERT_NEXT(a_out_hold,
                   out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_req_o),
                   "stalled result changed")

  // zero divisor forces a zero quotient
  `SRD_ASSERT_SAME(a_dz_zero,
                   out_valid_o && out_req_o.divide_by_zero,
                   out_req_o.quotient == '0,
                   "zero divisor gave nonzero quotient")

  // input side only backs up while a result is waiting
  `SRD_ASSERT_SAME(a_stall_needs_result,
                   in_stall_o,
                   out_valid_o,
                   "input stalled with no result pending")

  // one taken result frees the input side
  `SRD_ASSERT_NEXT(a_stall_clears,
                   in_stall_o && !out_stall_i,
                   !in_stall_o,
                   "input stall did not clear after drain")

endmodule

bind softmax_reciprocal_divider srd_checker u_srd_checker (.*);
